// ===== hdl/plane_window_stereo_cost_defines.svh =====
// Assertion macros used by the checker file.
`ifndef PLANE_WINDOW_STEREO_COST_DEFINES_SVH
`define PLANE_WINDOW_STEREO_COST_DEFINES_SVH
// Assert a property on clk with reset disable.
`define PWSC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Assert that a signal is never unknown after reset.
`define PWSC_KNOWN(label, sig, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !$isunknown(sig)) \
        else $error(msg);
`endif

// ===== hdl/pwsc_pkg.sv =====
// Package: shared types and constants of the window cost block.
package pwsc_pkg;
    localparam int CHANNELS = 3;
    localparam logic [1:0] REG_MAX_DISP = 2'd0;
    localparam logic [1:0] REG_TAU_CLR  = 2'd1;
    localparam logic [1:0] REG_TAU_GRD  = 2'd2;
    localparam logic [1:0] REG_ALPHA    = 2'd3;
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_TABLE = 1'b1;
    localparam logic [47:0] ACC_MAX = {48{1'b1}};
    localparam logic [39:0] OUT_MAX = {40{1'b1}};

    // Per-pixel control carried along the pipeline.
    typedef struct packed {
        logic valid;
        logic last;
        logic bad;
    } pix_ctl_t;
endpackage

// ===== hdl/pwsc_ram.sv =====
// Generic single-port write, single-port registered-read RAM.
module pwsc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== hdl/pwsc_lane.sv =====
// One interpolation lane: |(q - c) * 2^F + w * (c - fl)| for one channel.
module pwsc_lane #(
    parameter int FRACTION_BITS = 8,
    parameter int VW = 9
) (
    input  logic signed [VW-1:0]        q,
    input  logic signed [VW-1:0]        c,
    input  logic signed [VW-1:0]        fl,
    input  logic [FRACTION_BITS:0]      w,
    output logic [VW+FRACTION_BITS+1:0] mag
);
    localparam int RW = VW + FRACTION_BITS + 3;
    logic signed [RW-1:0] a;
    logic signed [RW-1:0] b;
    logic signed [RW-1:0] s;

    // Difference at integer pixel plus weighted bracket slope
    always_comb
    begin
        a = RW'(q - c) <<< FRACTION_BITS;
        b = RW'(c - fl) * $signed({1'b0, w});
        s = a + b;
        mag = s[RW-1] ? (VW+FRACTION_BITS+2)'(-s) : (VW+FRACTION_BITS+2)'(s);
    end
endmodule

// ===== hdl/plane_window_stereo_cost.sv =====
// Top level: slanted-plane stereo window cost accumulator.
// One window pixel or table write is taken every clock unless the output is
// held; after its last pixel, the result of a window passes the stage 1 to 4
// registers and then the output register. Three color lanes and one gradient
// lane run side by side and merge into an averaged, capped, alpha-blended cost
// that is weighted by the table entry at the center-neighbor SAD. The weight
// table is one RAM with a registered read; its unwritten entries are undefined.
// The pipeline stalls as a whole whenever the output register is held.
module plane_window_stereo_cost #(
    parameter int WEIGHT_ENTRIES = 1024,
    parameter int FRACTION_BITS = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               cmd,
    input  logic [23:0]        center_color,
    input  logic [23:0]        neighbor_color,
    input  logic [23:0]        floor_color,
    input  logic [23:0]        ceil_color,
    input  logic [26:0]        grad_triplet,
    input  logic signed [16:0] plane_disparity,
    input  logic               view_select,
    input  logic               last_in_window,
    input  logic [9:0]         table_index,
    input  logic [15:0]        table_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [39:0]        window_cost
);
    import pwsc_pkg::*;

    localparam int AW = $clog2(WEIGHT_ENTRIES);
    localparam int F = FRACTION_BITS;
    localparam int CW = 8 + F + 2;
    localparam int GW = 9 + F + 2;

    logic [7:0]  max_disp_reg;
    logic [15:0] tau_clr_reg, tau_grd_reg, alpha_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_disp_reg <= 8'd64;
            tau_clr_reg  <= 16'd2560;
            tau_grd_reg  <= 16'd512;
            alpha_reg    <= 16'd58982;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MAX_DISP: max_disp_reg <= cfg_data[7:0];
                REG_TAU_CLR:  tau_clr_reg  <= cfg_data;
                REG_TAU_GRD:  tau_grd_reg  <= cfg_data;
                REG_ALPHA:    alpha_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    logic adv;
    assign adv = !(out_valid && out_stall);
    assign in_stall = !adv;

    logic acc_in;
    assign acc_in = in_valid && adv;

    // Stage 0: SAD, disparity checks, lanes
    logic [9:0] sad;
    logic       sad_ok;
    logic signed [16-F:0] dfl;
    logic [F-1:0] frac;
    logic [F:0]   w;
    logic bad;
    logic [CW:0]   cmag [CHANNELS];
    logic [GW-1:0] gmag;

    always_comb
    begin
        sad = '0;
        for (int k = 0; k < CHANNELS; k++)
        begin
            if (center_color[8*k+:8] > neighbor_color[8*k+:8])
                sad = sad + 10'(center_color[8*k+:8] - neighbor_color[8*k+:8]);
            else
                sad = sad + 10'(neighbor_color[8*k+:8] - center_color[8*k+:8]);
        end
        sad_ok = 32'(sad) < WEIGHT_ENTRIES;
        dfl  = plane_disparity[16:F];
        frac = plane_disparity[F-1:0];
        bad  = (dfl <= 0) || (dfl >= $signed({1'b0, max_disp_reg}));
        if (view_select)
            w = (F+1)'(1 << F) - (F+1)'(frac);
        else
            w = (frac == '0) ? (F+1)'(1 << F) : (F+1)'(frac);
    end

    for (genvar k = 0; k < CHANNELS; k++)
    begin : g_lane
        pwsc_lane #(.FRACTION_BITS(F), .VW(9)) u_lane (
            .q  ($signed({1'b0, neighbor_color[8*k+:8]})),
            .c  ($signed({1'b0, ceil_color[8*k+:8]})),
            .fl ($signed({1'b0, floor_color[8*k+:8]})),
            .w  (w),
            .mag(cmag[k])
        );
    end

    logic [GW:0] gmag_w;
    pwsc_lane #(.FRACTION_BITS(F), .VW(10)) u_glane (
        .q  ($signed({grad_triplet[8], grad_triplet[8:0]})),
        .c  ($signed({grad_triplet[26], grad_triplet[26:18]})),
        .fl ($signed({grad_triplet[17], grad_triplet[17:9]})),
        .w  (w),
        .mag(gmag_w)
    );
    assign gmag = GW'(gmag_w);

    pix_ctl_t       c1_reg;
    logic [CW+1:0]  csum1_reg;
    logic [GW-1:0]  g1_reg;
    logic           sadok1_reg;

    logic [AW-1:0] ram_raddr;
    logic [AW-1:0] ram_raddr_hold_reg;
    logic [15:0]   ram_rdata;
    logic          ram_we;
    assign ram_we = acc_in && cmd == CMD_TABLE && 32'(table_index) < WEIGHT_ENTRIES;
    assign ram_raddr = AW'(sad);

    pwsc_ram #(.WIDTH(16), .DEPTH(WEIGHT_ENTRIES)) u_wt (
        .clk  (clk),
        .we   (ram_we),
        .waddr(AW'(table_index)),
        .wdata(table_value),
        .raddr(adv ? ram_raddr : ram_raddr_hold_reg),
        .rdata(ram_rdata)
    );

    // Stage 1 register: merged lane sums
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c1_reg <= '0;
        else if (adv)
            c1_reg <= '{valid: acc_in && cmd == CMD_PIXEL, last: last_in_window, bad: bad};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            csum1_reg  <= (CW+2)'(cmag[0]) + (CW+2)'(cmag[1]) + (CW+2)'(cmag[2]) + 1'b1;
            g1_reg     <= gmag;
            sadok1_reg <= sad_ok;
            ram_raddr_hold_reg <= ram_raddr;
        end
    end

    // Stage 2: divide by three via reciprocal, cap
    localparam int RB = CW + 4;
    localparam logic [RB:0] RECIP = (RB+1)'(((64'd1 << (RB + 2)) + 64'd2) / 3);
    logic [2*RB+2:0] prod;
    logic [CW+1:0]   q3;
    logic [CW+1:0]   q3f;
    logic [15:0]     clr, grd;

    always_comb
    begin
        prod = (2*RB+3)'(csum1_reg) * (2*RB+3)'(RECIP);
        q3 = (CW+2)'(prod >> (RB + 2));
        q3f = q3;
        if ((CW+4)'(q3) * 3 > (CW+4)'(csum1_reg))
            q3f = q3 - 1'b1;
        else if ((CW+4)'(q3 + 1'b1) * 3 <= (CW+4)'(csum1_reg))
            q3f = q3 + 1'b1;
        if (c1_reg.bad || (CW+2 > 16 ? q3f > (CW+2)'(tau_clr_reg) : 32'(q3f) > 32'(tau_clr_reg)))
            clr = tau_clr_reg;
        else
            clr = 16'(q3f);
        if (c1_reg.bad || 32'(g1_reg) > 32'(tau_grd_reg))
            grd = tau_grd_reg;
        else
            grd = 16'(g1_reg);
    end

    pix_ctl_t    c2_reg;
    logic [15:0] clr2_reg, grd2_reg, wgt2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c2_reg <= '0;
        else if (adv)
            c2_reg <= c1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            clr2_reg <= clr;
            grd2_reg <= grd;
            wgt2_reg <= sadok1_reg ? ram_rdata : 16'd0;
        end
    end

    // Stage 3: blend products
    pix_ctl_t    c3_reg;
    logic [32:0] blend3_reg;
    logic [15:0] wgt3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c3_reg <= '0;
        else if (adv)
            c3_reg <= c2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            blend3_reg <= 33'(32'(alpha_reg) * 32'(clr2_reg))
                + 33'(33'(17'h10000 - 17'(alpha_reg)) * 33'(grd2_reg));
            wgt3_reg <= wgt2_reg;
        end
    end

    // Stage 4: weight product and rounding
    pix_ctl_t    c4_reg;
    logic [17:0] contrib4_reg;
    logic [48:0] wprod;
    assign wprod = 49'(wgt3_reg) * 49'(blend3_reg) + 49'(64'd1 << 31);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c4_reg <= '0;
        else if (adv)
            c4_reg <= c3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            contrib4_reg <= 18'(wprod[48:32]);
    end

    // Stage 5: accumulate with saturation, emit on last
    logic [47:0] acc_reg, acc_next;
    logic [48:0] acc_sum;
    logic        out_valid_reg;
    logic [39:0] cost_reg;

    always_comb
    begin
        acc_sum  = 49'(acc_reg) + 49'(contrib4_reg);
        acc_next = acc_sum[48] ? ACC_MAX : acc_sum[47:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= c4_reg.valid && c4_reg.last;
            if (c4_reg.valid)
                acc_reg <= c4_reg.last ? 48'd0 : acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && c4_reg.valid && c4_reg.last)
            cost_reg <= (acc_next[47:40] != '0) ? OUT_MAX : acc_next[39:0];
    end

    assign out_valid = out_valid_reg;
    assign window_cost = cost_reg;
endmodule

// ===== hdl/pwsc_checker.sv =====
// Port-level checker for the window cost block, bound to the top level.
`include "plane_window_stereo_cost_defines.svh"
module pwsc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [39:0] window_cost
);
    logic held;
    assign held = out_valid && out_stall;

    `PWSC_ASSERT(a_out_hold, held |=> out_valid && $stable(window_cost), "held output moved")
    `PWSC_ASSERT(a_stall_src, in_stall |-> held, "input stalled without output backpressure")
    `PWSC_ASSERT(a_reset_idle, $rose(rst_n) |-> !out_valid, "output valid out of reset")
    `PWSC_KNOWN(a_known, out_valid, "output valid unknown")
endmodule

bind plane_window_stereo_cost pwsc_checker u_pwsc_checker (
    .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .window_cost(window_cost)
);
